// ===== rtl/yuvds_pkg.sv =====
package yuvds_pkg;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;

  // Store limit and line limit
  localparam int STORE_DEPTH_MAX = 2048;
  localparam int MAX_ROWS        = 4096;

  // Default for the top-level parameter
  localparam int DEF_MAX_LINE_PIXELS = 4096;

  // Register reset values
  localparam int RST_LINE_WIDTH   = 720;
  localparam int RST_FRAME_HEIGHT = 576;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Access request to the chroma line store
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } store_req_t;

  // Chroma pair read back from the line store
  typedef struct packed {
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } chroma_pair_t;

endpackage

// ===== rtl/yuvds_if.sv =====
interface yuvds_in_if;
  logic                        valid;
  logic                        ready;
  logic [yuvds_pkg::PIX_W-1:0] luma_a_in;
  logic [yuvds_pkg::PIX_W-1:0] chroma_u_in;
  logic [yuvds_pkg::PIX_W-1:0] luma_b_in;
  logic [yuvds_pkg::PIX_W-1:0] chroma_v_in;

  modport source (output valid, output luma_a_in, output chroma_u_in,
                  output luma_b_in, output chroma_v_in, input ready);
  modport sink (input valid, input luma_a_in, input chroma_u_in,
                input luma_b_in, input chroma_v_in, output ready);
endinterface

interface yuvds_out_if;
  logic                        valid;
  logic                        ready;
  logic [yuvds_pkg::PIX_W-1:0] luma_a_out;
  logic [yuvds_pkg::PIX_W-1:0] luma_b_out;
  logic [yuvds_pkg::PIX_W-1:0] u_avg;
  logic [yuvds_pkg::PIX_W-1:0] v_avg;
  logic                        chroma_valid;
  logic                        line_end;
  logic                        frame_end;

  modport source (output valid, output luma_a_out, output luma_b_out,
                  output u_avg, output v_avg, output chroma_valid,
                  output line_end, output frame_end, input ready);
  modport sink (input valid, input luma_a_out, input luma_b_out,
                input u_avg, input v_avg, input chroma_valid,
                input line_end, input frame_end, output ready);
endinterface

// ===== rtl/yuvds_line_store.sv =====
module yuvds_line_store #(
  parameter int DEPTH = yuvds_pkg::STORE_DEPTH_MAX
) (
  input  logic                    clk,
  input  yuvds_pkg::store_req_t   req,
  output yuvds_pkg::chroma_pair_t rd_data
);
  import yuvds_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  chroma_pair_t mem [DEPTH];
  chroma_pair_t rd_data_r;

  // Store the pair on even lines
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[ADDR_W-1:0]] <= '{u: req.u, v: req.v};
    end
  end

  // Fetch the pair on odd lines; hold it while the pipeline stalls
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr[ADDR_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/yuyv422_to_yuv420_chroma_downsampler.sv =====
// YUYV 4:2:2 to 4:2:0 vertical chroma downsampler.
// in_px takes one packed macropixel (two luma samples, one U, one V) per
// item in raster order; out_px gives one result item per input item, with
// luma passed through and, on odd lines, U and V averaged (truncated) with
// the pair stored from the line above, flagged by chroma_valid. line_end
// and frame_end mark the last macropixel of a line and of a frame.
// cfg_we/cfg_idx/cfg_wdata write line_width (index 0) and frame_height
// (index 1); write them only while no item is in flight.
// An accepted item is registered in the first stage and then in the
// output register. Throughput is one item per cycle while out_px.ready
// is high; the line store read port is registered and sets the first stage.
// Reset clears the column and row counters, the pipeline and the
// registers (720 x 576); the line store is not cleared, since each entry
// is written on an even line before an odd line reads it.
// When the receiver stalls, the output register holds its item, the
// middle stage fills, and in_px.ready falls until out_px.ready returns.
module yuyv422_to_yuv420_chroma_downsampler #(
  parameter int MAX_LINE_PIXELS = yuvds_pkg::DEF_MAX_LINE_PIXELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  yuvds_in_if.sink                        in_px,
  yuvds_out_if.source                     out_px,
  input  logic                            cfg_we,
  input  logic [yuvds_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [yuvds_pkg::CFG_W-1:0]     cfg_wdata
);
  import yuvds_pkg::*;

  // Macropixels per line, bounded by the store
  localparam int CAP_RAW     = MAX_LINE_PIXELS / 2;
  localparam int CAP_HI      = (CAP_RAW > STORE_DEPTH_MAX) ? STORE_DEPTH_MAX : CAP_RAW;
  localparam int STORE_DEPTH = (CAP_HI < 1) ? 1 : CAP_HI;
  localparam int RST_MP      = RST_LINE_WIDTH / 2;
  localparam int RST_LAST_COL = ((RST_MP > STORE_DEPTH) ? STORE_DEPTH : RST_MP) - 1;
  localparam int RST_LAST_ROW = RST_FRAME_HEIGHT - 1;
  localparam logic [CFG_W-1:0] CAP_V  = CFG_W'(STORE_DEPTH);
  localparam logic [CFG_W-1:0] ROWS_V = CFG_W'(MAX_ROWS);

  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] mp_cnt, line_cnt;

  logic             in_acc, lend, fend;
  logic             s1_vld_r, s1_move;
  logic [PIX_W-1:0] s1_ya_r, s1_yb_r, s1_u_r, s1_v_r;
  logic             s1_odd_r, s1_lend_r, s1_fend_r;

  logic             out_vld_r, out_load;
  logic [PIX_W-1:0] out_ya_r, out_yb_r, out_u_r, out_v_r;
  logic             out_cv_r, out_lend_r, out_fend_r;

  logic [PIX_W:0]   sum_u, sum_v;
  store_req_t       st_req;
  chroma_pair_t     st_rd;

  // Clamp register writes into last column and last row
  always_comb begin
    mp_cnt = {1'b0, cfg_wdata[CFG_W-1:1]};
    if (mp_cnt == '0) begin
      mp_cnt = CFG_W'(1);
    end
    if (mp_cnt > CAP_V) begin
      mp_cnt = CAP_V;
    end
    line_cnt = cfg_wdata;
    if (line_cnt == '0) begin
      line_cnt = CFG_W'(1);
    end
    if (line_cnt > ROWS_V) begin
      line_cnt = ROWS_V;
    end
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_LINE_WIDTH:   last_col_nxt = COL_W'(mp_cnt - CFG_W'(1));
        CFG_FRAME_HEIGHT: last_row_nxt = ROW_W'(line_cnt - CFG_W'(1));
        default: ;
      endcase
    end
  end

  // Handshakes
  assign out_load    = !out_vld_r || out_px.ready;
  assign s1_move     = s1_vld_r && out_load;
  assign in_px.ready = !s1_vld_r || out_load;
  assign in_acc      = in_px.valid && in_px.ready;

  // Advance the column and row counters
  always_comb begin
    lend    = col_r >= last_col_r;
    fend    = lend && (row_r >= last_row_r);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (lend) begin
        col_nxt = '0;
        row_nxt = fend ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Write on even lines, read on odd lines
  always_comb begin
    st_req.wr_en = in_acc && !row_r[0];
    st_req.rd_en = in_acc && row_r[0];
    st_req.addr  = col_r;
    st_req.u     = in_px.chroma_u_in;
    st_req.v     = in_px.chroma_v_in;
  end

  yuvds_line_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (st_rd)
  );

  // Average stored and current chroma
  assign sum_u = {1'b0, st_rd.u} + {1'b0, s1_u_r};
  assign sum_v = {1'b0, st_rd.v} + {1'b0, s1_v_r};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(RST_LAST_COL);
      last_row_r <= ROW_W'(RST_LAST_ROW);
      col_r      <= '0;
      row_r      <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      if (in_px.ready) begin
        s1_vld_r <= in_acc;
      end
      if (out_load) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // Payload: capture the item, then the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ya_r   <= in_px.luma_a_in;
      s1_yb_r   <= in_px.luma_b_in;
      s1_u_r    <= in_px.chroma_u_in;
      s1_v_r    <= in_px.chroma_v_in;
      s1_odd_r  <= row_r[0];
      s1_lend_r <= lend;
      s1_fend_r <= fend;
    end
    if (s1_move) begin
      out_ya_r   <= s1_ya_r;
      out_yb_r   <= s1_yb_r;
      out_u_r    <= s1_odd_r ? sum_u[PIX_W:1] : '0;
      out_v_r    <= s1_odd_r ? sum_v[PIX_W:1] : '0;
      out_cv_r   <= s1_odd_r;
      out_lend_r <= s1_lend_r;
      out_fend_r <= s1_fend_r;
    end
  end

  assign out_px.valid        = out_vld_r;
  assign out_px.luma_a_out   = out_ya_r;
  assign out_px.luma_b_out   = out_yb_r;
  assign out_px.u_avg        = out_u_r;
  assign out_px.v_avg        = out_v_r;
  assign out_px.chroma_valid = out_cv_r;
  assign out_px.line_end     = out_lend_r;
  assign out_px.frame_end    = out_fend_r;

endmodule
